// ===== design/modbus_rtu_register_slave_defines.svh =====
// assertion macros for the modbus rtu register slave
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef MODBUS_RTU_REGISTER_SLAVE_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_DEFINES_SVH

// same-cycle implication
`define MRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/mrs_pkg.sv =====
// shared types, constants and crc helpers of the modbus rtu register slave
// no dependencies
package mrs_pkg;

  localparam int unsigned FrameBytesDef = 256;
  localparam int unsigned StoreBytesDef = 1024;
  localparam int unsigned ReplyCap      = 256;

  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] ReadMaxQty = 16'h007D;

  localparam logic [7:0] FnRead          = 8'h03;
  localparam logic [7:0] FnWriteSingle   = 8'h06;
  localparam logic [7:0] FnWriteMultiple = 8'h10;
  localparam logic [7:0] ExcFlag         = 8'h80;
  localparam logic [7:0] ExcIllegalValue = 8'h03;
  localparam logic [7:0] ExcIllegalAddr  = 8'h02;
  localparam logic [7:0] ExcNotReady     = 8'h00;
  localparam logic [7:0] SlaveAddrRst    = 8'h01;

  // register byte addresses on the config port
  localparam logic [1:0] RegSlaveAddr = 2'd0;

  typedef enum logic [12:0] {
    S_CLR   = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_CHECK = 13'b0000000000100,
    S_W6A   = 13'b0000000001000,
    S_W6B   = 13'b0000000010000,
    S_MRD   = 13'b0000000100000,
    S_MWR   = 13'b0000001000000,
    S_PRE   = 13'b0000010000000,
    S_BRD   = 13'b0000100000000,
    S_BPUSH = 13'b0001000000000,
    S_CLO   = 13'b0010000000000,
    S_CHI   = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } mrs_state_e;

  // one reply byte from the sequencer to the packer
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } mrs_push_t;

  // table entry of the reflected crc-16
  function automatic logic [15:0] crc_tab(input logic [7:0] idx);
    logic [15:0] c;
    c = {8'h00, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    return (c >> 8) ^ crc_tab(c[7:0] ^ b);
  endfunction

endpackage

// ===== design/mrs_if.sv =====
// valid/ready channel interfaces for request bytes and reply groups
// no dependencies
interface mrs_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  logic       store_ready;

  modport source (output valid, rx_byte, frame_end, store_ready, input ready);
  modport sink (input valid, rx_byte, frame_end, store_ready, output ready);
endinterface

interface mrs_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte0;
  logic [7:0] tx_byte1;
  logic [7:0] tx_byte2;
  logic [7:0] tx_byte3;
  logic [2:0] byte_count;
  logic       reply_last;

  modport source (output valid, tx_byte0, tx_byte1, tx_byte2, tx_byte3, byte_count,
                  reply_last, input ready);
  modport sink (input valid, tx_byte0, tx_byte1, tx_byte2, tx_byte3, byte_count,
                reply_last, output ready);
endinterface

// ===== design/mrs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mrs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/mrs_crc.sv =====
// shared crc-16 unit, one byte per cycle through the table form
// depends on mrs_pkg
module mrs_crc import mrs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        upd_i,
  input  logic        start_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q, crc_d;

  // restart from the seed on the first byte of a run
  always_comb begin
    crc_d = crc_q;
    if (upd_i) begin
      crc_d = crc_next(start_i ? CrcInit : crc_q, byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CrcInit;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

// ===== design/mrs_packer.sv =====
// packs reply bytes into groups of up to four and holds them for the tx channel
// depends on mrs_pkg and mrs_if
module mrs_packer import mrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  mrs_push_t push_i,
  output logic      ready_o,
  mrs_rsp_if.source tx_if
);

  logic [7:0] byte_q [4];
  logic [1:0] cnt_q;
  logic [2:0] count_q;
  logic       last_q;
  logic       vld_q;

  assign ready_o = !vld_q;

  // group assembly, slots past the count stay zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (tx_if.valid && tx_if.ready) begin
        vld_q <= 1'b0;
      end
      if (push_i.valid) begin
        if (cnt_q == 2'd3 || push_i.last) begin
          vld_q <= 1'b1;
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      if (cnt_q == 2'd0) begin
        byte_q[0] <= push_i.data;
        byte_q[1] <= '0;
        byte_q[2] <= '0;
        byte_q[3] <= '0;
      end else begin
        byte_q[cnt_q] <= push_i.data;
      end
      count_q <= 3'({1'b0, cnt_q}) + 3'd1;
      last_q  <= push_i.last;
    end
  end

  assign tx_if.valid      = vld_q;
  assign tx_if.tx_byte0   = byte_q[0];
  assign tx_if.tx_byte1   = byte_q[1];
  assign tx_if.tx_byte2   = byte_q[2];
  assign tx_if.tx_byte3   = byte_q[3];
  assign tx_if.byte_count = count_q;
  assign tx_if.reply_last = last_q;

endmodule

// ===== design/modbus_rtu_register_slave.sv =====
// top level of the modbus rtu holding-register slave: sequencer, frame buffer,
// register store, crc unit and reply packer; depends on mrs_pkg, mrs_if, mrs_ram,
// mrs_crc, mrs_packer and modbus_rtu_register_slave_defines.svh
//
// Usage: request bytes arrive on rx_if, one per transfer, frame_end on the last
// byte. At frame end the address and crc are checked (the crc runs along as
// bytes arrive) and the reply is built byte by byte through the one crc unit:
// header and crc bytes are pushed straight from registers, each byte from the
// register store or the frame buffer is a ram read, then a push, and each byte
// written by function 16 is a frame buffer read, then a store write. A header
// or crc byte pushed right behind a full group waits until tx_if takes it.
// rx_if.ready stays low from frame end until the reply is handed over. Replies
// leave on tx_if in groups of up to four bytes, reply_last on the final group.
// When tx_if stalls, the held group stays put and the sequencer waits; the next
// request byte is taken once the last group of a reply is in the output stage.
// After reset the register store is cleared one byte a cycle, with rx_if.ready
// low; config writes are taken throughout.
// slave_address sits at byte address 0 of the apb port, reset value 1.
`include "modbus_rtu_register_slave_defines.svh"

module modbus_rtu_register_slave import mrs_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FrameBytesDef,
  parameter int unsigned STORE_BYTES = StoreBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrs_req_if.sink     rx_if,
  mrs_rsp_if.source   tx_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AwF = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam int unsigned AwS = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned Lw  = $clog2(FRAME_BYTES + 1);

  mrs_state_e  state_q, state_d;
  logic [7:0]  addr_q;
  logic [Lw-1:0] len_q;
  logic        ovf_q;
  logic [7:0]  hdr_q [7];
  logic [7:0]  prev_q, last_q;
  logic [15:0] m1_q, m2_q;
  logic        rdy_q;
  logic [7:0]  pfx_q [8];
  logic [2:0]  pfx_n_q;
  logic [8:0]  body_len_q;
  logic        body_store_q;
  logic        seal_q;
  logic [16:0] base_q;
  logic [7:0]  bcnt_q;
  logic [8:0]  idx_q;
  logic        first_q;
  logic        zero_q;
  logic [AwS-1:0] clr_q;

  // apb config port
  assign pready = 1'b1;
  assign prdata = (paddr == RegSlaveAddr) ? {24'h0, addr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= SlaveAddrRst;
    end else if (psel && penable && pwrite && paddr == RegSlaveAddr) begin
      addr_q <= pwdata[7:0];
    end
  end

  // rx side
  logic rx_fire, keep, start;
  assign rx_if.ready = (state_q == S_IDLE);
  assign rx_fire     = rx_if.valid && rx_if.ready;
  assign keep        = 11'(len_q) < 11'(FRAME_BYTES);
  assign start       = (len_q == '0);

  // frame check and decode
  logic [7:0]  func;
  logic [15:0] raddr, rval;
  logic [16:0] base;
  logic        good, exc, run;
  logic [7:0]  exc_code;
  logic [17:0] sum03, sum06, sum16;

  assign func  = hdr_q[1];
  assign raddr = {hdr_q[2], hdr_q[3]};
  assign rval  = {hdr_q[4], hdr_q[5]};
  assign base  = {raddr, 1'b0};
  assign sum03 = 18'(base) + 18'({rval, 1'b0});
  assign sum06 = 18'(base) + 18'd2;
  assign sum16 = 18'(base) + 18'(hdr_q[6]);
  assign good  = !ovf_q && 11'(len_q) >= 11'd4 && hdr_q[0] == addr_q &&
                 m2_q == {last_q, prev_q};

  always_comb begin
    exc      = 1'b0;
    run      = 1'b0;
    exc_code = ExcNotReady;
    if (func == FnRead) begin
      priority if (rval == 16'h0 || rval > ReadMaxQty) begin
        exc = 1'b1; exc_code = ExcIllegalValue;
      end else if (sum03 > 18'(STORE_BYTES)) begin
        exc = 1'b1; exc_code = ExcIllegalAddr;
      end else if (!rdy_q) begin
        exc = 1'b1; exc_code = ExcNotReady;
      end else begin
        run = 1'b1;
      end
    end else if (func == FnWriteSingle) begin
      priority if (sum06 > 18'(STORE_BYTES)) begin
        exc = 1'b1; exc_code = ExcIllegalAddr;
      end else if (!rdy_q) begin
        exc = 1'b1; exc_code = ExcNotReady;
      end else begin
        run = 1'b1;
      end
    end else if (func == FnWriteMultiple) begin
      priority if (sum16 > 18'(STORE_BYTES)) begin
        exc = 1'b1; exc_code = ExcIllegalAddr;
      end else if (!rdy_q) begin
        exc = 1'b1; exc_code = ExcNotReady;
      end else begin
        run = 1'b1;
      end
    end
  end

  // packer handshake
  mrs_push_t push;
  logic      pk_ready;
  logic [7:0] store_rdata, buf_rdata;
  logic [15:0] crc;
  logic       body_end;

  assign body_end = (idx_q == body_len_q - 9'd1);

  always_comb begin
    push = '0;
    unique case (state_q)
      S_PRE: begin
        push.valid = pk_ready;
        push.data  = pfx_q[idx_q[2:0]];
      end
      S_BPUSH: begin
        push.valid = pk_ready;
        push.data  = body_store_q ? store_rdata : buf_rdata;
        push.last  = body_end && !seal_q;
      end
      S_CLO: begin
        push.valid = pk_ready;
        push.data  = crc[7:0];
      end
      S_CHI: begin
        push.valid = pk_ready;
        push.data  = crc[15:8];
        push.last  = 1'b1;
      end
      default: push = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:   if (clr_q == AwS'(STORE_BYTES - 1)) state_d = S_IDLE;
      S_IDLE:  if (rx_fire && rx_if.frame_end) state_d = S_CHECK;
      S_CHECK: begin
        priority if (!good || (!exc && !run)) begin
          state_d = S_FIN;
        end else if (exc || func == FnRead) begin
          state_d = S_PRE;
        end else if (func == FnWriteSingle) begin
          state_d = S_W6A;
        end else begin
          state_d = (hdr_q[6] == 8'h0) ? S_PRE : S_MRD;
        end
      end
      S_W6A:   state_d = S_W6B;
      S_W6B:   state_d = S_BRD;
      S_MRD:   state_d = S_MWR;
      S_MWR:   state_d = (idx_q + 9'd1 == 9'(bcnt_q)) ? S_PRE : S_MRD;
      S_PRE: begin
        if (pk_ready && idx_q == 9'(pfx_n_q) - 9'd1) begin
          state_d = (body_len_q != '0) ? S_BRD : S_CLO;
        end
      end
      S_BRD:   state_d = S_BPUSH;
      S_BPUSH: begin
        if (pk_ready) begin
          priority if (!body_end) state_d = S_BRD;
          else if (seal_q)        state_d = S_CLO;
          else                    state_d = S_FIN;
        end
      end
      S_CLO:   if (pk_ready) state_d = S_CHI;
      S_CHI:   if (pk_ready) state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      clr_q   <= '0;
      idx_q   <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_CLR: clr_q <= clr_q + AwS'(1);
        S_IDLE: begin
          if (rx_fire) begin
            if (keep) len_q <= len_q + Lw'(1);
            else      ovf_q <= 1'b1;
          end
        end
        S_CHECK: begin
          idx_q   <= '0;
          first_q <= 1'b1;
        end
        S_MWR: idx_q <= (state_d == S_PRE) ? 9'd0 : idx_q + 9'd1;
        S_PRE: begin
          if (pk_ready) begin
            first_q <= 1'b0;
            idx_q   <= (state_d == S_PRE) ? idx_q + 9'd1 : 9'd0;
          end
        end
        S_BPUSH: begin
          if (pk_ready) begin
            first_q <= 1'b0;
            idx_q   <= (state_d == S_BRD) ? idx_q + 9'd1 : 9'd0;
          end
        end
        S_FIN: begin
          len_q <= '0;
          ovf_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      if (keep) begin
        if (start) hdr_q[0] <= rx_if.rx_byte;
        for (int k = 1; k < 7; k++) begin
          if (start) begin
            hdr_q[k] <= '0;
          end else if (11'(len_q) == 11'(k)) begin
            hdr_q[k] <= rx_if.rx_byte;
          end
        end
        prev_q <= last_q;
        last_q <= rx_if.rx_byte;
        m1_q   <= start ? CrcInit : crc;
        m2_q   <= start ? CrcInit : m1_q;
      end
      if (rx_if.frame_end) rdy_q <= rx_if.store_ready;
    end
    if (state_q == S_CHECK) begin
      base_q <= base;
      bcnt_q <= hdr_q[6];
      for (int k = 0; k < 8; k++) pfx_q[k] <= '0;
      body_store_q <= 1'b0;
      body_len_q   <= '0;
      seal_q       <= 1'b1;
      if (exc) begin
        pfx_q[0] <= addr_q;
        pfx_q[1] <= func | ExcFlag;
        pfx_q[2] <= exc_code;
        pfx_n_q  <= 3'd3;
      end else if (func == FnRead) begin
        pfx_q[0]     <= addr_q;
        pfx_q[1]     <= FnRead;
        pfx_q[2]     <= {rval[6:0], 1'b0};
        pfx_n_q      <= 3'd3;
        body_store_q <= 1'b1;
        body_len_q   <= {1'b0, rval[6:0], 1'b0};
      end else if (func == FnWriteSingle) begin
        pfx_n_q    <= 3'd0;
        seal_q     <= 1'b0;
        body_len_q <= (11'(len_q) > 11'(ReplyCap)) ? 9'(ReplyCap) : 9'(len_q);
      end else begin
        pfx_q[0] <= addr_q;
        pfx_q[1] <= FnWriteMultiple;
        pfx_q[2] <= hdr_q[2];
        pfx_q[3] <= hdr_q[3];
        pfx_q[4] <= hdr_q[4];
        pfx_q[5] <= hdr_q[5];
        pfx_n_q  <= 3'd6;
      end
    end
    if (state_q == S_MRD) begin
      zero_q <= (11'(idx_q) + 11'd7) >= 11'(len_q);
    end
  end

  // frame buffer
  logic           buf_re;
  logic [AwF-1:0] buf_raddr;
  assign buf_re    = (state_q == S_MRD) || (state_q == S_BRD && !body_store_q);
  assign buf_raddr = (state_q == S_MRD) ? AwF'(idx_q + 9'd7) : AwF'(idx_q);

  mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_buf (
    .clk_i   (clk_i),
    .we_i    (rx_fire && keep),
    .waddr_i (AwF'(len_q)),
    .wdata_i (rx_if.rx_byte),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // register store port selection
  logic           st_we;
  logic [AwS-1:0] st_waddr;
  logic [7:0]     st_wdata;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = AwS'(base_q + 17'(idx_q));
    st_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
      end
      S_W6A: begin
        st_we    = 1'b1;
        st_waddr = AwS'(base_q);
        st_wdata = hdr_q[4];
      end
      S_W6B: begin
        st_we    = 1'b1;
        st_waddr = AwS'(base_q + 17'd1);
        st_wdata = hdr_q[5];
      end
      S_MWR: begin
        st_we    = 1'b1;
        st_wdata = zero_q ? 8'h00 : buf_rdata;
      end
      default: st_we = 1'b0;
    endcase
  end

  mrs_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (state_q == S_BRD && body_store_q),
    .raddr_i (AwS'(base_q + 17'(idx_q))),
    .rdata_o (store_rdata)
  );

  // one crc unit for the request check and the reply seal
  logic       crc_upd, crc_start;
  logic [7:0] crc_byte;
  assign crc_upd   = (rx_fire && keep) ||
                     (push.valid && (state_q == S_PRE || state_q == S_BPUSH));
  assign crc_start = rx_fire ? start : first_q;
  assign crc_byte  = rx_fire ? rx_if.rx_byte : push.data;

  mrs_crc u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (crc_upd),
    .start_i (crc_start),
    .byte_i  (crc_byte),
    .crc_o   (crc)
  );

  mrs_packer u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (pk_ready),
    .tx_if   (tx_if)
  );

  // checks
  `MRS_ASSERT_IMP(a_clr_no_rx, state_q == S_CLR, !rx_if.ready, "rx transfer during clear pass")
  `MRS_ASSERT_IMP(a_push_room, push.valid, pk_ready, "push into a full packer")
  `MRS_ASSERT_IMP(a_len_bound, 1'b1, 11'(len_q) <= 11'(FRAME_BYTES), "frame length overrun")
  `MRS_ASSERT_NXT(a_last_fin, push.valid && push.last, state_q == S_FIN, "reply end not closed")

endmodule
